// ===== hdl/psar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psar_pkg
// Shared types and constants for the parabolic stop-and-reverse tracker.
// ----------------------------------------------------------------------------
package psar_pkg;

    // price and factor formats
    localparam int PRICE_WIDTH      = 32;
    localparam int FACTOR_WIDTH     = 16;
    localparam int FACTOR_FRAC_BITS = 16;
    localparam int PROD_WIDTH       = PRICE_WIDTH + FACTOR_WIDTH;
    localparam int CFG_INDEX_WIDTH  = 2;

    typedef logic signed [PRICE_WIDTH-1:0] t_price;
    typedef logic [FACTOR_WIDTH-1:0]       t_factor;

    localparam t_price PRICE_MAX = {1'b0, {(PRICE_WIDTH-1){1'b1}}};
    localparam t_price PRICE_MIN = {1'b1, {(PRICE_WIDTH-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ACCEL_START = 2'd0,
        CFG_ACCEL_STEP  = 2'd1,
        CFG_ACCEL_LIMIT = 2'd2
    } t_cfg_index;

    localparam t_factor ACCEL_START_RESET = 16'd1311;
    localparam t_factor ACCEL_STEP_RESET  = 16'd1311;
    localparam t_factor ACCEL_LIMIT_RESET = 16'd13107;

    // request operations
    localparam logic OP_NEW_BAR = 1'b0;
    localparam logic OP_REVISE  = 1'b1;

    typedef struct packed {
        t_factor accel_start;
        t_factor accel_step;
        t_factor accel_limit;
    } t_psar_cfg;

    typedef struct packed {
        logic   operation;
        logic   bar_valid;
        t_price bar_high;
        t_price bar_low;
        t_price bar_close;
    } t_bar_req;

    typedef struct packed {
        logic   sar_valid;
        t_price sar_level;
    } t_sar_rsp;

    // tracker state, also the layout of the snapshot
    typedef struct packed {
        logic    have_prior_bar;
        logic    have_second_prior;
        logic    trend_started;
        logic    going_long;
        t_factor accel_factor;
        t_price  extreme;
        t_price  stop;
        t_price  prior_high;
        t_price  prior_low;
        t_price  prior_close;
        t_price  second_high;
        t_price  second_low;
    } t_psar_state;

    localparam t_psar_state STATE_RESET = '{
        have_prior_bar:    1'b0,
        have_second_prior: 1'b0,
        trend_started:     1'b0,
        going_long:        1'b1,
        accel_factor:      '0,
        extreme:           '0,
        stop:              '0,
        prior_high:        '0,
        prior_low:         '0,
        prior_close:       '0,
        second_high:       '0,
        second_low:        '0
    };

endpackage

// ===== hdl/parabolic_sar_tracker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parabolic_sar_tracker_unit
// Parabolic stop-and-reverse tracker over a stream of price bars.
// ----------------------------------------------------------------------------
// An accepted request waits in the input register until the result register
// is free or being taken; the result register then loads its result.
// Throughput: 1 bar per cycle while the output is not stalled; the bar update
// (one 32x16 multiply plus compares) fits between input and result registers.
// Reset (synchronous, active low): clears tracker state, snapshot and both
// pipeline valid bits and loads the default factors; no clearing pass.
module parabolic_sar_tracker_unit
    import psar_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // bar requests
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  t_bar_req                   i_in_data,
    // stop results
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output t_sar_rsp                   o_out_data,
    // configuration writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  t_factor                    i_cfg_data
);

    t_psar_cfg   r_cfg;
    t_psar_state r_state;
    t_psar_state r_snap;
    logic        r_in_valid;
    t_bar_req    r_in_data;
    logic        r_out_valid;
    t_sar_rsp    r_out_data;

    t_psar_state n_state;
    t_psar_state n_snap;
    t_sar_rsp    n_rsp;

    logic        w_adv;
    logic        w_in_accept;

    // handshake
    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    psar_core u_core (
        .i_cfg   (r_cfg),
        .i_req   (r_in_data),
        .i_state (r_state),
        .i_snap  (r_snap),
        .o_state (n_state),
        .o_snap  (n_snap),
        .o_rsp   (n_rsp)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_start <= ACCEL_START_RESET;
            r_cfg.accel_step  <= ACCEL_STEP_RESET;
            r_cfg.accel_limit <= ACCEL_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ACCEL_START: r_cfg.accel_start <= i_cfg_data;
                CFG_ACCEL_STEP:  r_cfg.accel_step  <= i_cfg_data;
                CFG_ACCEL_LIMIT: r_cfg.accel_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_data <= i_in_data;
        end
    end

    // tracker state and snapshot advance with each processed bar
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_snap  <= STATE_RESET;
        end else if (w_adv) begin
            r_state <= n_state;
            r_snap  <= n_snap;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_rsp;
        end
    end

    // checks
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_held_bar_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_data))
        else $error("waiting bar lost or changed");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with room in pipeline");

    a_flags_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.trend_started |-> r_state.have_prior_bar) and
        (r_state.have_second_prior |-> r_state.trend_started))
        else $error("tracker flags out of order");

    a_missing_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data.sar_valid |-> r_out_data.sar_level == '0)
        else $error("level nonzero without stop");

endmodule

// ===== hdl/psar_move.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psar_move
// Moves the stop toward the extreme point by factor * distance, with the
// product magnitude truncated and the result saturated to the price range.
// ----------------------------------------------------------------------------
module psar_move
    import psar_pkg::*;
(
    input  t_price  i_stop,
    input  t_factor i_factor,
    input  t_price  i_extreme,
    output t_price  o_level
);

    logic                   w_up;
    logic [PRICE_WIDTH:0]   w_diff;
    logic [PRICE_WIDTH:0]   w_room_ext;
    logic [PRICE_WIDTH-1:0] w_mag;
    logic [PRICE_WIDTH-1:0] w_room;
    logic [PROD_WIDTH-1:0]  w_prod;
    logic [PROD_WIDTH-1:0]  w_step;
    logic                   w_sat;

    // distance magnitude, fits the price width as unsigned
    assign w_up   = (i_extreme >= i_stop);
    assign w_diff = w_up ? ({i_extreme[PRICE_WIDTH-1], i_extreme} - {i_stop[PRICE_WIDTH-1], i_stop})
                         : ({i_stop[PRICE_WIDTH-1], i_stop} - {i_extreme[PRICE_WIDTH-1], i_extreme});
    assign w_mag  = w_diff[PRICE_WIDTH-1:0];

    // scaled step, truncated toward zero
    assign w_prod = PROD_WIDTH'(w_mag) * PROD_WIDTH'(i_factor);
    assign w_step = w_prod >> FACTOR_FRAC_BITS;

    // headroom to the saturation limit in the direction of travel
    assign w_room_ext = w_up ? ({PRICE_MAX[PRICE_WIDTH-1], PRICE_MAX} - {i_stop[PRICE_WIDTH-1], i_stop})
                             : ({i_stop[PRICE_WIDTH-1], i_stop} - {PRICE_MIN[PRICE_WIDTH-1], PRICE_MIN});
    assign w_room     = w_room_ext[PRICE_WIDTH-1:0];
    assign w_sat      = (w_step > PROD_WIDTH'(w_room));

    // apply step or saturate
    always_comb begin
        if (w_sat) begin
            o_level = w_up ? PRICE_MAX : PRICE_MIN;
        end else if (w_up) begin
            o_level = i_stop + t_price'(w_step[PRICE_WIDTH-1:0]);
        end else begin
            o_level = i_stop - t_price'(w_step[PRICE_WIDTH-1:0]);
        end
    end

endmodule

// ===== hdl/psar_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psar_core
// Single-pass bar update: snapshot restore, trend start, stop move, reversal,
// factor growth and clamp to the prior two bars.
// ----------------------------------------------------------------------------
module psar_core
    import psar_pkg::*;
(
    input  t_psar_cfg   i_cfg,
    input  t_bar_req    i_req,
    input  t_psar_state i_state,
    input  t_psar_state i_snap,
    output t_psar_state o_state,
    output t_psar_state o_snap,
    output t_sar_rsp    o_rsp
);

    t_psar_state w_eff;
    logic        w_long;
    logic        w_first;
    t_price      w_ep;
    t_price      w_sar;
    t_factor     w_af;
    t_price      w_moved;

    // state seen by this bar: restored snapshot on a revise
    assign w_eff  = (i_req.operation == OP_REVISE) ? i_snap : i_state;
    assign o_snap = w_eff;

    // trend start overrides trend, extreme, stop and factor
    always_comb begin
        if (!w_eff.trend_started) begin
            w_long  = (i_req.bar_close > w_eff.prior_close);
            w_ep    = w_long ? i_req.bar_high : i_req.bar_low;
            w_sar   = w_long ? w_eff.prior_low : w_eff.prior_high;
            w_af    = i_cfg.accel_start;
            w_first = 1'b1;
        end else begin
            w_long  = w_eff.going_long;
            w_ep    = w_eff.extreme;
            w_sar   = w_eff.stop;
            w_af    = w_eff.accel_factor;
            w_first = 1'b0;
        end
    end

    psar_move u_move (
        .i_stop    (w_sar),
        .i_factor  (w_af),
        .i_extreme (w_ep),
        .o_level   (w_moved)
    );

    // reversal, factor growth, clamp and state update
    always_comb begin
        t_psar_state nxt;
        logic        long_now;
        logic        first;
        t_price      ns;
        t_price      ep;
        t_factor     af;
        logic [FACTOR_WIDTH:0] grown;

        nxt      = w_eff;
        long_now = w_long;
        first    = w_first;
        ns       = w_moved;
        ep       = w_ep;
        af       = w_af;
        grown    = '0;
        o_rsp    = '0;

        if (i_req.bar_valid) begin
            if (!w_eff.have_prior_bar) begin
                nxt.prior_high     = i_req.bar_high;
                nxt.prior_low      = i_req.bar_low;
                nxt.prior_close    = i_req.bar_close;
                nxt.have_prior_bar = 1'b1;
            end else begin
                // breach flips the trend
                if (w_long) begin
                    if (i_req.bar_low < w_moved) begin
                        first    = 1'b1;
                        long_now = 1'b0;
                        ns       = (i_req.bar_high > w_ep) ? i_req.bar_high : w_ep;
                        af       = i_cfg.accel_start;
                        ep       = i_req.bar_low;
                    end
                end else begin
                    if (i_req.bar_high > w_moved) begin
                        first    = 1'b1;
                        long_now = 1'b1;
                        ns       = (i_req.bar_low < w_ep) ? i_req.bar_low : w_ep;
                        af       = i_cfg.accel_start;
                        ep       = i_req.bar_high;
                    end
                end

                // new extreme raises the factor up to the limit
                if (!first) begin
                    if (long_now ? (i_req.bar_high > ep) : (i_req.bar_low < ep)) begin
                        ep    = long_now ? i_req.bar_high : i_req.bar_low;
                        grown = {1'b0, af} + {1'b0, i_cfg.accel_step};
                        af    = (grown < {1'b0, i_cfg.accel_limit}) ? grown[FACTOR_WIDTH-1:0]
                                                                    : i_cfg.accel_limit;
                    end
                end

                // keep the stop beyond the prior two bars
                if (long_now) begin
                    if (w_eff.prior_low < ns) begin
                        ns = w_eff.prior_low;
                    end
                    if (w_eff.have_second_prior && (w_eff.second_low < ns)) begin
                        ns = w_eff.second_low;
                    end
                end else begin
                    if (w_eff.prior_high > ns) begin
                        ns = w_eff.prior_high;
                    end
                    if (w_eff.have_second_prior && (w_eff.second_high > ns)) begin
                        ns = w_eff.second_high;
                    end
                end

                nxt.trend_started     = 1'b1;
                nxt.going_long        = long_now;
                nxt.accel_factor      = af;
                nxt.extreme           = ep;
                nxt.stop              = ns;
                nxt.second_high       = w_eff.prior_high;
                nxt.second_low        = w_eff.prior_low;
                nxt.prior_high        = i_req.bar_high;
                nxt.prior_low         = i_req.bar_low;
                nxt.prior_close       = i_req.bar_close;
                nxt.have_second_prior = 1'b1;

                o_rsp.sar_valid = 1'b1;
                o_rsp.sar_level = ns;
            end
        end

        o_state = nxt;
    end

endmodule
